// ----- rtl/uart_buffered_rx_tx_queues_core_defines.svh -----
// ----------------------------------------------------------------------------
// UART buffered queues: assertion macros
// Shared property forms for the port checker, clocked on clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef UART_BUFFERED_RX_TX_QUEUES_CORE_DEFINES_SVH
`define UART_BUFFERED_RX_TX_QUEUES_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UBRTQ_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ubrtq check failed");

// Consequent must hold in the cycle after the antecedent.
`define UBRTQ_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ubrtq check failed");

`endif

// ----- rtl/ubrtq_pkg.sv -----
// ----------------------------------------------------------------------------
// UART buffered queues: package
// Command codes, transfer payload types and ring control types.
// ----------------------------------------------------------------------------
package ubrtq_pkg;

   localparam int BYTE_W  = 8;
   localparam int CMD_W   = 3;
   localparam int COUNT_W = 7;

   // Event codes carried in the command field
   typedef enum logic [CMD_W-1:0] {
      CMD_LINE_RX    = 3'd0,
      CMD_TX_READY   = 3'd1,
      CMD_HOST_READ  = 3'd2,
      CMD_HOST_WRITE = 3'd3,
      CMD_READ_OVR   = 3'd4,
      CMD_READ_FRM   = 3'd5,
      CMD_FLUSH_RX   = 3'd6
   } cmd_type;

   // Input transfer
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] data;
      logic              framing_err;
      logic              line_overrun;
   } req_type;

   // Result transfer
   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               byte_valid;
      logic               accepted;
      logic [COUNT_W-1:0] rx_count;
      logic [COUNT_W-1:0] tx_free;
      logic               any_overrun;
      logic               queue_overrun;
      logic               framing_seen;
      logic               tx_active;
   } rsp_type;

   // Per-item result bits held in the result register
   typedef struct packed {
      logic byte_valid;
      logic accepted;
      logic any_overrun;
      logic queue_overrun;
      logic framing_seen;
      logic pop_tx;
   } rsp_flags_type;

   // Ring controls
   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_ctrl_type;

   // Ring status
   typedef struct packed {
      logic empty;
      logic full;
   } ring_stat_type;

endpackage

// ----- rtl/uart_buffered_rx_tx_queues_core.sv -----
// ----------------------------------------------------------------------------
// UART buffered queues core: result registered in the cycle after a request transfer.
// Throughput 1 event per cycle while results are taken; the ring read port and result register
// hold a stalled result, and a new request is taken as it leaves.
// Synchronous reset empties both rings, clears flags and transmit enable.
// ----------------------------------------------------------------------------
module uart_buffered_rx_tx_queues_core
   import ubrtq_pkg::*;
#(
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
   localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);

   ring_ctrl_type         rx_ctrl, tx_ctrl;
   ring_stat_type         rx_stat, tx_stat;
   logic [BYTE_W-1:0]     rx_rd_data, tx_rd_data;
   logic [RX_FILL_W-1:0]  rx_fill;
   logic [TX_FILL_W-1:0]  tx_fill;

   logic          fire;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_flags_type flags_ff, flags_in;
   logic          hw_ovr_ff, hw_ovr_in;
   logic          ring_ovr_ff, ring_ovr_in;
   logic          framing_ff, framing_in;
   logic          tx_en_ff, tx_en_in;

   assign fire      = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // Event decode and state update
   always_comb begin
      rx_ctrl     = '0;
      tx_ctrl     = '0;
      flags_in    = '0;
      hw_ovr_in   = hw_ovr_ff;
      ring_ovr_in = ring_ovr_ff;
      framing_in  = framing_ff;
      tx_en_in    = tx_en_ff;
      if (fire) begin
         unique case (req_data.command)
            CMD_LINE_RX: begin
               if (req_data.framing_err) framing_in = 1'b1;
               if (req_data.line_overrun) hw_ovr_in = 1'b1;
               if (!rx_stat.full) begin
                  rx_ctrl.push      = 1'b1;
                  flags_in.accepted = 1'b1;
               end else begin
                  ring_ovr_in = 1'b1;
               end
            end
            CMD_TX_READY: begin
               if (tx_en_ff) begin
                  if (!tx_stat.empty) begin
                     tx_ctrl.pop         = 1'b1;
                     flags_in.byte_valid = 1'b1;
                     flags_in.accepted   = 1'b1;
                     flags_in.pop_tx     = 1'b1;
                  end else begin
                     tx_en_in = 1'b0;
                  end
               end
            end
            CMD_HOST_READ: begin
               if (!rx_stat.empty) begin
                  rx_ctrl.pop         = 1'b1;
                  flags_in.byte_valid = 1'b1;
                  flags_in.accepted   = 1'b1;
               end
            end
            CMD_HOST_WRITE: begin
               if (!tx_stat.full) begin
                  tx_ctrl.push      = 1'b1;
                  tx_en_in          = 1'b1;
                  flags_in.accepted = 1'b1;
               end
            end
            CMD_READ_OVR: begin
               flags_in.queue_overrun = ring_ovr_ff;
               flags_in.any_overrun   = hw_ovr_ff || ring_ovr_ff;
               flags_in.accepted      = 1'b1;
               hw_ovr_in              = 1'b0;
               ring_ovr_in            = 1'b0;
            end
            CMD_READ_FRM: begin
               flags_in.framing_seen = framing_ff;
               flags_in.accepted     = 1'b1;
               framing_in            = 1'b0;
            end
            CMD_FLUSH_RX: begin
               rx_ctrl.flush     = 1'b1;
               hw_ovr_in         = 1'b0;
               ring_ovr_in       = 1'b0;
               framing_in        = 1'b0;
               flags_in.accepted = 1'b1;
            end
            default: begin
               // unused code: no effect, not accepted
            end
         endcase
      end
   end

   // Result valid: set on a request transfer, cleared on a result transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hw_ovr_ff    <= 1'b0;
         ring_ovr_ff  <= 1'b0;
         framing_ff   <= 1'b0;
         tx_en_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         hw_ovr_ff    <= hw_ovr_in;
         ring_ovr_ff  <= ring_ovr_in;
         framing_ff   <= framing_in;
         tx_en_ff     <= tx_en_in;
      end
   end

   // Result bits, loaded with each request transfer
   always_ff @(posedge clock) begin
      if (fire) begin
         flags_ff <= flags_in;
      end
   end

   ubrtq_ring #(
      .DEPTH (RX_DEPTH)
   ) u_rx_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (rx_ctrl),
      .wr_data (req_data.data),
      .rd_data (rx_rd_data),
      .fill    (rx_fill),
      .stat    (rx_stat)
   );

   ubrtq_ring #(
      .DEPTH (TX_DEPTH)
   ) u_tx_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (tx_ctrl),
      .wr_data (req_data.data),
      .rd_data (tx_rd_data),
      .fill    (tx_fill),
      .stat    (tx_stat)
   );

   // Result assembly; ring state already reflects the item on show
   always_comb begin
      rsp_data               = '0;
      rsp_data.byte_valid    = flags_ff.byte_valid;
      rsp_data.accepted      = flags_ff.accepted;
      rsp_data.any_overrun   = flags_ff.any_overrun;
      rsp_data.queue_overrun = flags_ff.queue_overrun;
      rsp_data.framing_seen  = flags_ff.framing_seen;
      rsp_data.rx_count      = COUNT_W'(rx_fill);
      rsp_data.tx_free       = COUNT_W'(TX_FILL_W'(TX_DEPTH) - tx_fill);
      rsp_data.tx_active     = tx_en_ff;
      if (flags_ff.byte_valid) begin
         rsp_data.out_byte = flags_ff.pop_tx ? tx_rd_data : rx_rd_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/ubrtq_ring.sv -----
// ----------------------------------------------------------------------------
// UART buffered queues: byte ring
// Circular byte store with head, tail and fill count. Pop data lands in a
// read register in the cycle after the pop and holds until the next pop.
// ----------------------------------------------------------------------------
module ubrtq_ring
   import ubrtq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ring_ctrl_type                ctrl,
   input  logic [BYTE_W-1:0]            wr_data,
   output logic [BYTE_W-1:0]            rd_data,
   output logic [$clog2(DEPTH+1)-1:0]   fill,
   output ring_stat_type                stat
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [BYTE_W-1:0] store_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // Pointer and count updates
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.flush) begin
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else begin
         if (ctrl.push) begin
            head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         end
         if (ctrl.pop) begin
            tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         end
         if (ctrl.push && !ctrl.pop) begin
            fill_in = fill_ff + FILL_W'(1);
         end else if (ctrl.pop && !ctrl.push) begin
            fill_in = fill_ff - FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Store write port
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         store_ff[head_ff] <= wr_data;
      end
   end

   // Registered read port, loaded on pop only
   always_ff @(posedge clock) begin
      if (ctrl.pop) begin
         rd_data_ff <= store_ff[tail_ff];
      end
   end

   assign rd_data    = rd_data_ff;
   assign fill       = fill_ff;
   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == FILL_W'(DEPTH));

endmodule

// ----- rtl/ubrtq_checker.sv -----
// ----------------------------------------------------------------------------
// UART buffered queues: port checker
// Watches the core's ports over time; bound to the core below.
// ----------------------------------------------------------------------------
`include "uart_buffered_rx_tx_queues_core_defines.svh"

module ubrtq_checker
   import ubrtq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // no result on show right after reset
   `UBRTQ_ASSERT_NOW(a_idle_after_reset, $past(reset), !rsp_valid)

   // a stalled result holds
   `UBRTQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // every request transfer yields a result next cycle
   `UBRTQ_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid)

   // flush empties the receive ring and is always accepted
   `UBRTQ_ASSERT_NEXT(a_flush_empty,
      req_valid && req_ready && req_data.command == CMD_FLUSH_RX,
      rsp_data.accepted && rsp_data.rx_count == '0 && !rsp_data.byte_valid)

endmodule

bind uart_buffered_rx_tx_queues_core ubrtq_checker u_checker (.*);
